/* hdl/ttm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the timer table manager.
// No dependencies; every other file of the block but ttm_ram imports this package.
package ttm_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_AW     = $clog2(TIMER_SLOTS);
  localparam int SLOT_CW     = $clog2(TIMER_SLOTS + 1);

  localparam int ID_W    = 32;
  localparam int TIME_W  = 48;
  localparam int AMT_W   = 24;
  localparam int KIND_W  = 3;
  localparam int ENTRY_W = TIME_W + ID_W;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_EXTEND   = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXTEND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              ok;
    logic              last;
  } res_t;

  // Sum of two times, clamped at the largest representable time.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* hdl/timer_table_manager_unit.sv */
// Timer table manager: a table of one-shot timers with an internal ms clock.
// Input channel (in_valid/in_stall) takes one command word: register, cancel,
// extend or tick. Each command gives one reply word on the result channel
// (out_valid/out_stall); a tick gives one fired word per expired timer,
// earliest first, then a tick-done word with out_last set.
// Slot ids and expiry times live in one synchronous RAM (TIMER_SLOTS deep,
// one read and one write port); the live bits are flops. Every search walks
// the table one slot per cycle: the register search over the live bits, the
// cancel, extend and tick scans over the RAM.
// One command is in work at a time; in_stall is high until its last word has
// been placed in the output register, so the next command can enter while
// that word still waits to be taken. A stalled receiver holds the output
// register and pauses the sequencer at its next result.
// Reset (rst_n low, synchronous) clears the live bits, id counter and clock
// at once; there is no clearing pass, since the RAM data of a slot is only
// used while its live bit is set.
`timescale 1ns / 1ps
// Depends on ttm_pkg, ttm_ram, ttm_out_buf and ttm_ctrl.
module timer_table_manager_unit
  import ttm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [AMT_W-1:0]  in_amount_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_result_id,
  output logic              out_ok,
  output logic              out_last
);

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_push;
  res_t               res;
  logic               res_free;

  ttm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_timer_id  (in_timer_id),
    .in_amount_ms (in_amount_ms),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .res_push     (res_push),
    .res          (res),
    .res_free     (res_free)
  );

  ttm_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (res_push),
    .res           (res),
    .free          (res_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_result_id (out_result_id),
    .out_ok        (out_ok),
    .out_last      (out_last)
  );

`ifndef SYNTH
  // An accepted command always keeps the sequencer busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // Only fired words leave last clear; every other kind closes its command.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_FIRE) != out_last))
    else $error("last flag does not match result kind");

  // Fired and tick-done words always report success.
  a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_FIRE || out_kind == KIND_DONE)) |-> out_ok)
    else $error("tick result without ok");
`endif

endmodule

/* hdl/ttm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ttm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ttm_out_buf.sv */
`timescale 1ns / 1ps
// Output register of the result channel: holds one result word until taken.
// Depends on ttm_pkg for the result type.
module ttm_out_buf
  import ttm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_result_id,
  output logic              out_ok,
  output logic              out_last
);

  logic vld_r;
  logic vld_nxt;
  res_t data_r;

  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign out_valid     = vld_r;
  assign out_kind      = data_r.kind;
  assign out_result_id = data_r.id;
  assign out_ok        = data_r.ok;
  assign out_last      = data_r.last;

endmodule

/* hdl/ttm_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the timer table: live bits, id counter, clock and slot scans.
// Depends on ttm_pkg; drives the slot RAM and the output register.
module ttm_ctrl
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [AMT_W-1:0]   in_amount_ms,
  output logic               ram_we,
  output logic [SLOT_AW-1:0] ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic [SLOT_AW-1:0] ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata,
  output logic               res_push,
  output res_t               res,
  input  logic               res_free
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_REG     = 3'd1;
  localparam logic [2:0] ST_CE_SCAN = 3'd2;
  localparam logic [2:0] ST_CE_ACT  = 3'd3;
  localparam logic [2:0] ST_TICK    = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             ret_r, ret_nxt;
  logic [TIMER_SLOTS-1:0] live_r, live_nxt;
  logic [ID_W-1:0]        id_cnt_r, id_cnt_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [SLOT_CW-1:0]     cnt_r, cnt_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [SLOT_AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic                   best_vld_r, best_vld_nxt;
  logic [SLOT_AW-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]      best_exp_r, best_exp_nxt;
  logic [ID_W-1:0]        best_id_r, best_id_nxt;
  logic [SLOT_AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [TIME_W-1:0]      hit_exp_r, hit_exp_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [ID_W-1:0]        tid_r, tid_nxt;
  logic [AMT_W-1:0]       amt_r, amt_nxt;
  res_t                   res_r, res_nxt;

  logic [SLOT_AW-1:0] scan_idx;
  logic               cnt_end;
  logic [TIME_W-1:0]  rd_exp;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  amt_ext;
  logic               ce_hit;
  logic               tick_cand;
  logic               tick_better;
  logic [KIND_W-1:0]  ce_kind;

  assign scan_idx    = cnt_r[SLOT_AW-1:0];
  assign cnt_end     = (cnt_r == SLOT_CW'(TIMER_SLOTS));
  assign rd_exp      = ram_rdata[ENTRY_W-1:ID_W];
  assign rd_id       = ram_rdata[ID_W-1:0];
  assign amt_ext     = {{(TIME_W-AMT_W){1'b0}}, amt_r};
  assign ce_hit      = rd_vld_r && live_r[rd_idx_r] && (rd_id == tid_r);
  assign tick_cand   = rd_vld_r && live_r[rd_idx_r] && (rd_exp <= now_r);
  // Earlier expiry wins, then lower id; a full tie keeps the lower slot.
  assign tick_better = !best_vld_r || ({rd_exp, rd_id} < {best_exp_r, best_id_r});
  assign ce_kind     = (op_r == OP_CANCEL) ? KIND_CANCEL : KIND_EXTEND;

  assign in_stall  = (state_r != ST_IDLE);
  assign ram_raddr = scan_idx;
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    live_nxt     = live_r;
    id_cnt_nxt   = id_cnt_r;
    now_nxt      = now_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_exp_nxt = best_exp_r;
    best_id_nxt  = best_id_r;
    hit_idx_nxt  = hit_idx_r;
    hit_exp_nxt  = hit_exp_r;
    op_nxt       = op_r;
    tid_nxt      = tid_r;
    amt_nxt      = amt_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = scan_idx;
    ram_wdata    = '0;
    res_push     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          tid_nxt      = in_timer_id;
          amt_nxt      = in_amount_ms;
          cnt_nxt      = '0;
          best_vld_nxt = 1'b0;
          unique case (in_opcode)
            OP_REGISTER: state_nxt = ST_REG;
            OP_CANCEL,
            OP_EXTEND:   state_nxt = ST_CE_SCAN;
            OP_TICK: begin
              now_nxt   = sat_add(now_r, {{(TIME_W-AMT_W){1'b0}}, in_amount_ms});
              state_nxt = ST_TICK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // Live bits sit in flops, so the free-slot search reads one per cycle.
      ST_REG: begin
        if (cnt_end) begin
          res_nxt   = '{kind: KIND_REGISTER, id: '0, ok: 1'b0, last: 1'b1};
          ret_nxt   = ST_IDLE;
          state_nxt = ST_EMIT;
        end else if (!live_r[scan_idx]) begin
          ram_we             = 1'b1;
          ram_waddr          = scan_idx;
          ram_wdata          = {sat_add(now_r, amt_ext), id_cnt_r + ID_W'(1)};
          live_nxt[scan_idx] = 1'b1;
          id_cnt_nxt         = id_cnt_r + ID_W'(1);
          res_nxt   = '{kind: KIND_REGISTER, id: id_cnt_r + ID_W'(1), ok: 1'b1,
                        last: 1'b1};
          ret_nxt   = ST_IDLE;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + SLOT_CW'(1);
        end
      end

      ST_CE_SCAN: begin
        if (ce_hit) begin
          hit_idx_nxt = rd_idx_r;
          hit_exp_nxt = rd_exp;
          state_nxt   = ST_CE_ACT;
        end else if (cnt_end && !rd_vld_r) begin
          res_nxt   = '{kind: ce_kind, id: tid_r, ok: 1'b0, last: 1'b1};
          ret_nxt   = ST_IDLE;
          state_nxt = ST_EMIT;
        end else if (!cnt_end) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_idx;
          cnt_nxt    = cnt_r + SLOT_CW'(1);
        end
      end

      ST_CE_ACT: begin
        if (op_r == OP_EXTEND) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_r;
          ram_wdata = {sat_add(hit_exp_r, amt_ext), tid_r};
        end else begin
          live_nxt[hit_idx_r] = 1'b0;
        end
        res_nxt   = '{kind: ce_kind, id: tid_r, ok: 1'b1, last: 1'b1};
        ret_nxt   = ST_IDLE;
        state_nxt = ST_EMIT;
      end

      // One full pass over the table per fired timer, then a last empty pass.
      ST_TICK: begin
        if (tick_cand && tick_better) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_exp_nxt = rd_exp;
          best_id_nxt  = rd_id;
        end
        if (cnt_end && !rd_vld_r) begin
          if (best_vld_r) begin
            live_nxt[best_idx_r] = 1'b0;
            res_nxt      = '{kind: KIND_FIRE, id: best_id_r, ok: 1'b1, last: 1'b0};
            ret_nxt      = ST_TICK;
            cnt_nxt      = '0;
            best_vld_nxt = 1'b0;
          end else begin
            res_nxt = '{kind: KIND_DONE, id: '0, ok: 1'b1, last: 1'b1};
            ret_nxt = ST_IDLE;
          end
          state_nxt = ST_EMIT;
        end else if (!cnt_end) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_idx;
          cnt_nxt    = cnt_r + SLOT_CW'(1);
        end
      end

      ST_EMIT: begin
        if (res_free) begin
          res_push  = 1'b1;
          state_nxt = ret_r;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ret_r      <= ST_IDLE;
      live_r     <= '0;
      id_cnt_r   <= '0;
      now_r      <= '0;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      live_r     <= live_nxt;
      id_cnt_r   <= id_cnt_nxt;
      now_r      <= now_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_exp_r <= best_exp_nxt;
    best_id_r  <= best_id_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_exp_r  <= hit_exp_nxt;
    op_r       <= op_nxt;
    tid_r      <= tid_nxt;
    amt_r      <= amt_nxt;
    res_r      <= res_nxt;
  end

endmodule
